/* rtl/core/complex_sample_statistics_top_defines.svh */
// Assertion macros used by the checker file of the statistics block.
`ifndef COMPLEX_SAMPLE_STATISTICS_TOP_DEFINES_SVH
`define COMPLEX_SAMPLE_STATISTICS_TOP_DEFINES_SVH

// Same-cycle implication under a synchronous reset.
`define CSS_ASSERT_IMP(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("css check failed");

// Next-cycle implication under a synchronous reset.
`define CSS_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("css check failed");

`endif

/* rtl/core/css_pkg.sv */
// Types and constants of the complex sample statistics block.
`timescale 1ns / 1ps
`default_nettype none
package css_pkg;
   localparam int SAMPLE_BITS     = 16;
   localparam int POW_W           = 2 * SAMPLE_BITS;
   localparam int AMP_W           = SAMPLE_BITS + 1;
   localparam int PTOT_W          = 48;
   localparam int ATOT_W          = 33;
   localparam int VAL_W           = 48;
   localparam int INDEX_W         = 16;
   localparam int SCALE_W         = 32;
   localparam int FRAC_BITS       = 24;
   localparam int QUEUE_DEPTH     = 4;
   localparam int MAX_SAMPLES_DEF = 65536;
   localparam int CSR_IDX_W       = 4;

   localparam logic [CSR_IDX_W-1:0] CSR_FFT_MODE  = 4'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_AMP_SCALE = 4'd1;
   localparam logic [SCALE_W-1:0]   AMP_SCALE_RST = 32'h0100_0000;

   localparam logic [3:0] STAT_MAX_I    = 4'd0;
   localparam logic [3:0] STAT_MIN_I    = 4'd1;
   localparam logic [3:0] STAT_MAX_Q    = 4'd2;
   localparam logic [3:0] STAT_MIN_Q    = 4'd3;
   localparam logic [3:0] STAT_MAX_POW  = 4'd4;
   localparam logic [3:0] STAT_MIN_POW  = 4'd5;
   localparam logic [3:0] STAT_TOT_POW  = 4'd6;
   localparam logic [3:0] STAT_MEAN_POW = 4'd7;
   localparam logic [3:0] STAT_MAX_AMP  = 4'd8;
   localparam logic [3:0] STAT_MIN_AMP  = 4'd9;
   localparam logic [3:0] STAT_TOT_AMP  = 4'd10;
   localparam logic [3:0] STAT_MEAN_AMP = 4'd11;

   typedef struct packed {
      logic signed [SAMPLE_BITS-1:0] sample_i;
      logic signed [SAMPLE_BITS-1:0] sample_q;
      logic                          block_end;
   } css_req_type;

   typedef struct packed {
      logic [3:0]              stat_code;
      logic signed [VAL_W-1:0] stat_value;
      logic [INDEX_W-1:0]      stat_index;
      logic                    clipped;
      logic                    run_last;
   } css_rsp_type;

   typedef struct packed {
      logic signed [SAMPLE_BITS-1:0] sample_i;
      logic signed [SAMPLE_BITS-1:0] sample_q;
      logic                          last;
   } css_item_type;
endpackage
`default_nettype wire

/* rtl/core/css_front.sv */
// Front end: accepts requests, numbers them within the block and queues them.
`timescale 1ns / 1ps
`default_nettype none
module css_front #(
   parameter int MAX_SAMPLES = css_pkg::MAX_SAMPLES_DEF
) (
   input  wire logic                         clock,
   input  wire logic                         reset,
   input  wire logic                         req_valid,
   output logic                              req_stall,
   input  wire css_pkg::css_req_type         req,
   output logic                              item_valid,
   input  wire logic                         item_pop,
   output css_pkg::css_item_type             item,
   output logic [$clog2(MAX_SAMPLES)-1:0]    item_idx
);
   localparam int IDX_W = $clog2(MAX_SAMPLES);
   localparam int PTR_W = $clog2(css_pkg::QUEUE_DEPTH);
   localparam int CNT_W = $clog2(css_pkg::QUEUE_DEPTH + 1);

   css_pkg::css_item_type q_ff [css_pkg::QUEUE_DEPTH];
   logic [IDX_W-1:0]      qidx_ff [css_pkg::QUEUE_DEPTH];
   logic [PTR_W-1:0]      wr_ff, wr_in, rd_ff, rd_in;
   logic [CNT_W-1:0]      cnt_ff, cnt_in;
   logic [IDX_W-1:0]      idx_ff, idx_in;
   logic                  push, last;

   assign req_stall  = (cnt_ff == CNT_W'(css_pkg::QUEUE_DEPTH));
   assign push       = req_valid && !req_stall;
   assign last       = req.block_end || (idx_ff == IDX_W'(MAX_SAMPLES - 1));
   assign item_valid = (cnt_ff != '0);
   assign item       = q_ff[rd_ff];
   assign item_idx   = qidx_ff[rd_ff];

   always_comb begin
      wr_in  = push ? wr_ff + 1'b1 : wr_ff;
      rd_in  = item_pop ? rd_ff + 1'b1 : rd_ff;
      cnt_in = cnt_ff + CNT_W'(push) - CNT_W'(item_pop);
      idx_in = idx_ff;
      if (push) begin
         idx_in = last ? '0 : idx_ff + 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff  <= '0;
         rd_ff  <= '0;
         cnt_ff <= '0;
         idx_ff <= '0;
      end else begin
         wr_ff  <= wr_in;
         rd_ff  <= rd_in;
         cnt_ff <= cnt_in;
         idx_ff <= idx_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         q_ff[wr_ff]    <= '{sample_i: req.sample_i, sample_q: req.sample_q, last: last};
         qidx_ff[wr_ff] <= idx_ff;
      end
   end
endmodule
`default_nettype wire

/* rtl/core/css_div.sv */
// Serial restoring divider, one quotient bit per cycle.
`timescale 1ns / 1ps
`default_nettype none
module css_div #(
   parameter int DW = css_pkg::PTOT_W,
   parameter int NW = 17
) (
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire logic          start,
   input  wire logic [DW-1:0] dividend,
   input  wire logic [NW-1:0] divisor,
   output logic               done,
   output logic [DW-1:0]      quotient
);
   localparam int CW = $clog2(DW + 1);

   logic [DW-1:0] quo_ff, quo_in;
   logic [NW-1:0] rem_ff, rem_in, dvs_ff, dvs_in;
   logic [CW-1:0] cnt_ff, cnt_in;
   logic          busy_ff, busy_in, done_ff, done_in;
   logic [NW:0]   rem_sh;
   logic          ge;

   assign rem_sh   = {rem_ff, quo_ff[DW-1]};
   assign ge       = (rem_sh >= {1'b0, dvs_ff});
   assign done     = done_ff;
   assign quotient = quo_ff;

   always_comb begin
      quo_in  = quo_ff;
      rem_in  = rem_ff;
      dvs_in  = dvs_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (start) begin
         quo_in  = dividend;
         rem_in  = '0;
         dvs_in  = divisor;
         cnt_in  = CW'(DW);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         rem_in = ge ? NW'(rem_sh - {1'b0, dvs_ff}) : rem_sh[NW-1:0];
         quo_in = {quo_ff[DW-2:0], ge};
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == CW'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      dvs_ff <= dvs_in;
   end
endmodule
`default_nettype wire

/* rtl/core/css_back.sv */
// Back end: power, amplitude and statistics update, means and result output.
`timescale 1ns / 1ps
`default_nettype none
module css_back #(
   parameter int MAX_SAMPLES = css_pkg::MAX_SAMPLES_DEF
) (
   input  wire logic                               clock,
   input  wire logic                               reset,
   input  wire logic                               item_valid,
   output logic                                    item_pop,
   input  wire css_pkg::css_item_type              item,
   input  wire logic [$clog2(MAX_SAMPLES)-1:0]     item_idx,
   input  wire logic                               fft_mode,
   input  wire logic [css_pkg::SCALE_W-1:0]        amp_scale,
   output logic                                    rsp_valid,
   input  wire logic                               rsp_stall,
   output css_pkg::css_rsp_type                    rsp
);
   localparam int IDX_W = $clog2(MAX_SAMPLES);
   localparam int CNT_W = $clog2(MAX_SAMPLES + 1);
   localparam int SB    = css_pkg::SAMPLE_BITS;
   localparam int PW    = css_pkg::POW_W;
   localparam int AW    = css_pkg::AMP_W;
   localparam int PTW   = css_pkg::PTOT_W;
   localparam int ATW   = css_pkg::ATOT_W;
   localparam int VW    = css_pkg::VAL_W;
   localparam int PRW   = SB + css_pkg::SCALE_W;
   localparam int RW    = SB + 4;
   localparam int ITW   = $clog2(SB);
   localparam logic [PTW:0] PTOT_MAX = {2'b00, {(PTW-1){1'b1}}};
   localparam logic [ATW:0] ATOT_MAX = {1'b0, {ATW{1'b1}}};

   typedef enum logic [11:0] {
      ST_IDLE   = 12'b0000_0000_0001,
      ST_SQI    = 12'b0000_0000_0010,
      ST_SQQ    = 12'b0000_0000_0100,
      ST_ROOT   = 12'b0000_0000_1000,
      ST_SCALE  = 12'b0000_0001_0000,
      ST_SAT    = 12'b0000_0010_0000,
      ST_SQAMP  = 12'b0000_0100_0000,
      ST_UPDATE = 12'b0000_1000_0000,
      ST_DIVP0  = 12'b0001_0000_0000,
      ST_DIVP   = 12'b0010_0000_0000,
      ST_DIVA   = 12'b0100_0000_0000,
      ST_EMIT   = 12'b1000_0000_0000
   } state_type;

   state_type               state_ff, state_in;
   logic signed [SB-1:0]    si_ff, si_in, sq_ff, sq_in;
   logic                    last_ff, last_in;
   logic [IDX_W-1:0]        idx_ff, idx_in;
   logic [PW-1:0]           pw_ff, pw_in, x_ff, x_in;
   logic [RW-1:0]           rem_ff, rem_in;
   logic [SB-1:0]           root_ff, root_in, amp_ff, amp_in;
   logic [ITW-1:0]          it_ff, it_in;
   logic [PRW-1:0]          prod_ff, prod_in;
   logic [CNT_W-1:0]        n_ff, n_in;
   logic [VW-1:0]           mpow_ff, mpow_in, mamp_ff, mamp_in;
   logic signed [SB-1:0]    imax_ff, imax_in, imin_ff, imin_in;
   logic signed [SB-1:0]    qmax_ff, qmax_in, qmin_ff, qmin_in;
   logic [IDX_W-1:0]        xi_ff [6];
   logic [IDX_W-1:0]        xi_in [6];
   logic [PW-1:0]           pmax_ff, pmax_in, pmin_ff, pmin_in;
   logic [PTW-1:0]          ptot_ff, ptot_in;
   logic [AW-1:0]           amax_ff, amax_in, amin_ff, amin_in;
   logic [ATW-1:0]          atot_ff, atot_in;
   logic                    clip_ff, clip_in;
   logic [3:0]              k_ff, k_in;
   logic                    rsp_valid_ff, rsp_valid_in;
   css_pkg::css_rsp_type    rsp_ff, rsp_in, result;

   logic signed [PW-1:0]    si_w, sq_w;
   logic [RW-1:0]           rem_sh, trial;
   logic                    ge;
   logic [SB-1:0]           root_nx;
   logic [PTW:0]            psum;
   logic [ATW:0]            asum;
   logic [AW-1:0]           amp_x;
   logic                    div_start, div_done, load;
   logic [PTW-1:0]          div_a, div_q;
   logic [IDX_W+15:0]       idx_wide;
   logic [css_pkg::INDEX_W-1:0] res_idx;

   css_div #(.DW(PTW), .NW(CNT_W)) u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (div_a),
      .divisor  (n_ff),
      .done     (div_done),
      .quotient (div_q)
   );

   assign si_w     = PW'(si_ff);
   assign sq_w     = PW'(sq_ff);
   assign rem_sh   = {rem_ff[RW-3:0], x_ff[PW-1:PW-2]};
   assign trial    = {2'b00, root_ff, 2'b01};
   assign ge       = (rem_sh >= trial);
   assign root_nx  = {root_ff[SB-2:0], ge};
   assign amp_x    = AW'(amp_ff);
   assign psum     = {1'b0, ptot_ff} + (PTW+1)'(pw_ff);
   assign asum     = {1'b0, atot_ff} + (ATW+1)'(amp_ff);
   assign item_pop = (state_ff == ST_IDLE) && item_valid;
   assign load     = !rsp_valid_ff || !rsp_stall;
   assign rsp_valid = rsp_valid_ff;
   assign rsp       = rsp_ff;

   always_comb begin
      case (k_ff)
         css_pkg::STAT_MAX_I:   idx_wide = (IDX_W+16)'(xi_ff[0]);
         css_pkg::STAT_MIN_I:   idx_wide = (IDX_W+16)'(xi_ff[1]);
         css_pkg::STAT_MAX_Q:   idx_wide = (IDX_W+16)'(xi_ff[2]);
         css_pkg::STAT_MIN_Q:   idx_wide = (IDX_W+16)'(xi_ff[3]);
         css_pkg::STAT_MAX_POW: idx_wide = (IDX_W+16)'(xi_ff[4]);
         css_pkg::STAT_MIN_POW: idx_wide = (IDX_W+16)'(xi_ff[5]);
         default:               idx_wide = '0;
      endcase
      res_idx = idx_wide[15:0];
   end

   always_comb begin
      result = '0;
      result.stat_code  = k_ff;
      result.stat_index = res_idx;
      result.clipped    = clip_ff;
      result.run_last   = (k_ff == css_pkg::STAT_MEAN_AMP);
      case (k_ff)
         css_pkg::STAT_MAX_I:    result.stat_value = VW'(imax_ff);
         css_pkg::STAT_MIN_I:    result.stat_value = VW'(imin_ff);
         css_pkg::STAT_MAX_Q:    result.stat_value = VW'(qmax_ff);
         css_pkg::STAT_MIN_Q:    result.stat_value = VW'(qmin_ff);
         css_pkg::STAT_MAX_POW:  result.stat_value = VW'(pmax_ff);
         css_pkg::STAT_MIN_POW:  result.stat_value = VW'(pmin_ff);
         css_pkg::STAT_TOT_POW:  result.stat_value = VW'(ptot_ff);
         css_pkg::STAT_MEAN_POW: result.stat_value = mpow_ff;
         css_pkg::STAT_MAX_AMP:  result.stat_value = VW'(amax_ff);
         css_pkg::STAT_MIN_AMP:  result.stat_value = VW'(amin_ff);
         css_pkg::STAT_TOT_AMP:  result.stat_value = VW'(atot_ff);
         css_pkg::STAT_MEAN_AMP: result.stat_value = mamp_ff;
         default:                result.stat_value = '0;
      endcase
   end

   always_comb begin
      state_in     = state_ff;
      si_in        = si_ff;
      sq_in        = sq_ff;
      last_in      = last_ff;
      idx_in       = idx_ff;
      pw_in        = pw_ff;
      x_in         = x_ff;
      rem_in       = rem_ff;
      root_in      = root_ff;
      amp_in       = amp_ff;
      it_in        = it_ff;
      prod_in      = prod_ff;
      n_in         = n_ff;
      mpow_in      = mpow_ff;
      mamp_in      = mamp_ff;
      imax_in      = imax_ff;
      imin_in      = imin_ff;
      qmax_in      = qmax_ff;
      qmin_in      = qmin_ff;
      xi_in        = xi_ff;
      pmax_in      = pmax_ff;
      pmin_in      = pmin_ff;
      ptot_in      = ptot_ff;
      amax_in      = amax_ff;
      amin_in      = amin_ff;
      atot_in      = atot_ff;
      clip_in      = clip_ff;
      k_in         = k_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_in       = rsp_ff;
      div_start    = 1'b0;
      div_a        = ptot_ff;
      if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
      unique case (state_ff)
         ST_IDLE: begin
            if (item_valid) begin
               si_in    = item.sample_i;
               sq_in    = item.sample_q;
               last_in  = item.last;
               idx_in   = item_idx;
               state_in = ST_SQI;
            end
         end
         ST_SQI: begin
            pw_in    = PW'(si_w * si_w);
            state_in = ST_SQQ;
         end
         ST_SQQ: begin
            pw_in    = pw_ff + PW'(sq_w * sq_w);
            x_in     = pw_in;
            rem_in   = '0;
            root_in  = '0;
            it_in    = '0;
            state_in = ST_ROOT;
         end
         ST_ROOT: begin
            rem_in  = ge ? rem_sh - trial : rem_sh;
            root_in = root_nx;
            x_in    = {x_ff[PW-3:0], 2'b00};
            it_in   = it_ff + 1'b1;
            if (it_ff == ITW'(SB - 1)) begin
               amp_in   = root_nx;
               state_in = fft_mode ? ST_SCALE : ST_UPDATE;
            end
         end
         ST_SCALE: begin
            prod_in  = PRW'(amp_ff) * PRW'(amp_scale);
            state_in = ST_SAT;
         end
         ST_SAT: begin
            if (prod_ff[PRW-1:css_pkg::FRAC_BITS+SB] != '0) begin
               amp_in  = '1;
               clip_in = 1'b1;
            end else begin
               amp_in = prod_ff[css_pkg::FRAC_BITS+SB-1:css_pkg::FRAC_BITS];
            end
            state_in = ST_SQAMP;
         end
         ST_SQAMP: begin
            pw_in    = PW'(amp_ff) * PW'(amp_ff);
            state_in = ST_UPDATE;
         end
         ST_UPDATE: begin
            if (si_ff > imax_ff) begin
               imax_in  = si_ff;
               xi_in[0] = idx_ff;
            end
            if (si_ff < imin_ff) begin
               imin_in  = si_ff;
               xi_in[1] = idx_ff;
            end
            if (sq_ff > qmax_ff) begin
               qmax_in  = sq_ff;
               xi_in[2] = idx_ff;
            end
            if (sq_ff < qmin_ff) begin
               qmin_in  = sq_ff;
               xi_in[3] = idx_ff;
            end
            if (pw_ff > pmax_ff) begin
               pmax_in  = pw_ff;
               xi_in[4] = idx_ff;
            end
            if (pw_ff < pmin_ff) begin
               pmin_in  = pw_ff;
               xi_in[5] = idx_ff;
            end
            ptot_in = (psum > PTOT_MAX) ? PTOT_MAX[PTW-1:0] : psum[PTW-1:0];
            if (amp_x > amax_ff) begin
               amax_in = amp_x;
            end
            if (amp_x < amin_ff) begin
               amin_in = amp_x;
            end
            atot_in  = (asum > ATOT_MAX) ? ATOT_MAX[ATW-1:0] : asum[ATW-1:0];
            n_in     = CNT_W'(idx_ff) + 1'b1;
            state_in = last_ff ? ST_DIVP0 : ST_IDLE;
         end
         ST_DIVP0: begin
            div_start = 1'b1;
            state_in  = ST_DIVP;
         end
         ST_DIVP: begin
            if (div_done) begin
               mpow_in   = div_q;
               div_start = 1'b1;
               div_a     = PTW'(atot_ff);
               state_in  = ST_DIVA;
            end
         end
         ST_DIVA: begin
            if (div_done) begin
               mamp_in  = div_q;
               k_in     = '0;
               state_in = ST_EMIT;
            end
         end
         ST_EMIT: begin
            if (load) begin
               rsp_valid_in = 1'b1;
               rsp_in       = result;
               k_in         = k_ff + 1'b1;
               if (k_ff == css_pkg::STAT_MEAN_AMP) begin
                  imax_in  = {1'b1, {(SB-1){1'b0}}};
                  imin_in  = {1'b0, {(SB-1){1'b1}}};
                  qmax_in  = {1'b1, {(SB-1){1'b0}}};
                  qmin_in  = {1'b0, {(SB-1){1'b1}}};
                  xi_in    = '{default: '0};
                  pmax_in  = '0;
                  pmin_in  = '1;
                  ptot_in  = '0;
                  amax_in  = '0;
                  amin_in  = '1;
                  atot_in  = '0;
                  clip_in  = 1'b0;
                  state_in = ST_IDLE;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         k_ff         <= '0;
         rsp_valid_ff <= 1'b0;
         imax_ff      <= {1'b1, {(SB-1){1'b0}}};
         imin_ff      <= {1'b0, {(SB-1){1'b1}}};
         qmax_ff      <= {1'b1, {(SB-1){1'b0}}};
         qmin_ff      <= {1'b0, {(SB-1){1'b1}}};
         xi_ff        <= '{default: '0};
         pmax_ff      <= '0;
         pmin_ff      <= '1;
         ptot_ff      <= '0;
         amax_ff      <= '0;
         amin_ff      <= '1;
         atot_ff      <= '0;
         clip_ff      <= 1'b0;
      end else begin
         state_ff     <= state_in;
         k_ff         <= k_in;
         rsp_valid_ff <= rsp_valid_in;
         imax_ff      <= imax_in;
         imin_ff      <= imin_in;
         qmax_ff      <= qmax_in;
         qmin_ff      <= qmin_in;
         xi_ff        <= xi_in;
         pmax_ff      <= pmax_in;
         pmin_ff      <= pmin_in;
         ptot_ff      <= ptot_in;
         amax_ff      <= amax_in;
         amin_ff      <= amin_in;
         atot_ff      <= atot_in;
         clip_ff      <= clip_in;
      end
   end

   always_ff @(posedge clock) begin
      si_ff   <= si_in;
      sq_ff   <= sq_in;
      last_ff <= last_in;
      idx_ff  <= idx_in;
      pw_ff   <= pw_in;
      x_ff    <= x_in;
      rem_ff  <= rem_in;
      root_ff <= root_in;
      amp_ff  <= amp_in;
      it_ff   <= it_in;
      prod_ff <= prod_in;
      n_ff    <= n_in;
      mpow_ff <= mpow_in;
      mamp_ff <= mamp_in;
      rsp_ff  <= rsp_in;
   end
endmodule
`default_nettype wire

/* rtl/core/complex_sample_statistics_top.sv */
// Top level of the complex sample statistics block.
// Each request carries one Q1.15 I/Q sample; the back end works on one sample at a
// time through squaring, the 16-step square-root loop and, in FFT mode, the
// scaling multiplies. A four-entry queue lets requests arrive in bursts.
// The last sample of a block adds two serial divisions for the means,
// then twelve results leave at one per cycle while the output is not stalled.
`timescale 1ns / 1ps
`default_nettype none
module complex_sample_statistics_top #(
   parameter int MAX_SAMPLES = css_pkg::MAX_SAMPLES_DEF
) (
   input  wire logic                           clock,
   input  wire logic                           reset,
   input  wire logic                           req_valid,
   output logic                                req_stall,
   input  wire css_pkg::css_req_type           req_data,
   output logic                                rsp_valid,
   input  wire logic                           rsp_stall,
   output css_pkg::css_rsp_type                rsp_data,
   input  wire logic                           csr_valid,
   output logic                                csr_ready,
   input  wire logic [css_pkg::CSR_IDX_W-1:0]  csr_index,
   input  wire logic [css_pkg::SCALE_W-1:0]    csr_wdata
);
   localparam int IDX_W = $clog2(MAX_SAMPLES);

   logic                          fft_ff, fft_in;
   logic [css_pkg::SCALE_W-1:0]   scale_ff, scale_in;
   logic                          item_valid, item_pop;
   css_pkg::css_item_type         item;
   logic [IDX_W-1:0]              item_idx;

   assign csr_ready = 1'b1;

   always_comb begin
      fft_in   = fft_ff;
      scale_in = scale_ff;
      if (csr_valid && csr_ready) begin
         unique case (csr_index)
            css_pkg::CSR_FFT_MODE:  fft_in   = csr_wdata[0];
            css_pkg::CSR_AMP_SCALE: scale_in = csr_wdata;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fft_ff   <= 1'b0;
         scale_ff <= css_pkg::AMP_SCALE_RST;
      end else begin
         fft_ff   <= fft_in;
         scale_ff <= scale_in;
      end
   end

   css_front #(.MAX_SAMPLES(MAX_SAMPLES)) u_front (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_stall  (req_stall),
      .req        (req_data),
      .item_valid (item_valid),
      .item_pop   (item_pop),
      .item       (item),
      .item_idx   (item_idx)
   );

   css_back #(.MAX_SAMPLES(MAX_SAMPLES)) u_back (
      .clock      (clock),
      .reset      (reset),
      .item_valid (item_valid),
      .item_pop   (item_pop),
      .item       (item),
      .item_idx   (item_idx),
      .fft_mode   (fft_ff),
      .amp_scale  (scale_ff),
      .rsp_valid  (rsp_valid),
      .rsp_stall  (rsp_stall),
      .rsp        (rsp_data)
   );
endmodule
`default_nettype wire

/* rtl/core/css_checker.sv */
// Port-level checks of the complex sample statistics block and their binding.
`timescale 1ns / 1ps
`default_nettype none
`include "complex_sample_statistics_top_defines.svh"
module css_checker (
   input wire logic                 clock,
   input wire logic                 reset,
   input wire logic                 rsp_valid,
   input wire logic                 rsp_stall,
   input wire css_pkg::css_rsp_type rsp
);
   `CSS_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && rsp_stall, rsp_valid && $stable(rsp))
   `CSS_ASSERT_IMP(a_last_code, clock, reset, rsp_valid && rsp.run_last, rsp.stat_code == css_pkg::STAT_MEAN_AMP)
   `CSS_ASSERT_IMP(a_code_last, clock, reset, rsp_valid && rsp.stat_code == css_pkg::STAT_MEAN_AMP, rsp.run_last)
   `CSS_ASSERT_IMP(a_no_index, clock, reset, rsp_valid && rsp.stat_code >= css_pkg::STAT_TOT_POW, rsp.stat_index == '0)
endmodule

bind complex_sample_statistics_top css_checker u_css_checker (
   .clock     (clock),
   .reset     (reset),
   .rsp_valid (rsp_valid),
   .rsp_stall (rsp_stall),
   .rsp       (rsp_data)
);
`default_nettype wire
